// ----- sv/mcrqs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrqs_pkg
// Shared types and constants of the multi-CPU ready queue scheduler.
// ----------------------------------------------------------------------------
package mcrqs_pkg;

  localparam int DEF_QUEUE_DEPTH = 32;
  localparam int DEF_MAX_CPUS    = 16;
  localparam int CMDQ_DEPTH      = 4;

  localparam logic [2:0] OP_WAKE      = 3'd0;
  localparam logic [2:0] OP_PREEMPT   = 3'd1;
  localparam logic [2:0] OP_YIELD     = 3'd2;
  localparam logic [2:0] OP_TERMINATE = 3'd3;
  localparam logic [2:0] OP_IDLE      = 3'd4;

  localparam logic [1:0] MODE_FIFO = 2'd0;
  localparam logic [1:0] MODE_RR   = 2'd1;
  localparam logic [1:0] MODE_PRIO = 2'd2;

  localparam logic [1:0] REG_SCHED_MODE  = 2'd0;
  localparam logic [1:0] REG_SLICE_TICKS = 2'd1;
  localparam logic [1:0] REG_ACTIVE_CPUS = 2'd2;

  localparam logic KIND_DISPATCH = 1'b0;
  localparam logic KIND_PREEMPT  = 1'b1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] cpu_index;
    logic [7:0] proc_id;
    logic [7:0] proc_priority;
  } cmd_t;

  // back end -> ready queue
  typedef struct packed {
    logic       ins;
    logic       prio_mode;
    logic [7:0] ins_proc;
    logic [7:0] ins_prio;
    logic       pop;
  } rq_ctrl_t;

endpackage
`default_nettype wire

// ----- sv/mcrqs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrqs_front
// Input side: accepts items into a short command queue for the back end.
// ----------------------------------------------------------------------------
module mcrqs_front import mcrqs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire cmd_t       in_cmd,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_pop
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t            mem [CMDQ_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            push;
  logic            pop;

  assign in_stall  = (count == (PW+1)'(CMDQ_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_cmd;
  end

endmodule
`default_nettype wire

// ----- sv/mcrqs_rdyq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrqs_rdyq
// Ready queue: shift array with in-place insert (ordered by priority in priority mode) and head pop.
// ----------------------------------------------------------------------------
module mcrqs_rdyq import mcrqs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rq_ctrl_t    ctrl,
  output logic [CW-1:0]    count,
  output logic             full,
  output logic [7:0]       head_proc,
  output logic [7:0]       head_prio
);

  logic [7:0]             q_proc [QUEUE_DEPTH];
  logic [7:0]             q_prio [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] stay;

  assign full      = (count == CW'(QUEUE_DEPTH));
  assign head_proc = q_proc[0];
  assign head_prio = q_prio[0];

  // Entries ahead of the insert point stay. The first entry past count or with
  // a larger priority ends the prefix; the queue may be unsorted after a mode
  // change, so later entries do not restart it.
  always_comb begin
    logic keep;
    keep = 1'b1;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep    = keep && (CW'(i) < count) &&
                (!ctrl.prio_mode || (q_prio[i] <= ctrl.ins_prio));
      stay[i] = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins && !full) begin
      count <= count + 1'b1;
    end else if (ctrl.pop && count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (ctrl.ins && !full) begin
        if (!stay[i]) begin
          if (i == 0) begin
            q_proc[i] <= ctrl.ins_proc;
            q_prio[i] <= ctrl.ins_prio;
          end else if (stay[(i == 0) ? 0 : i-1]) begin
            q_proc[i] <= ctrl.ins_proc;
            q_prio[i] <= ctrl.ins_prio;
          end else begin
            q_proc[i] <= q_proc[(i == 0) ? 0 : i-1];
            q_prio[i] <= q_prio[(i == 0) ? 0 : i-1];
          end
        end
      end else if (ctrl.pop && i < QUEUE_DEPTH-1) begin
        q_proc[i] <= q_proc[(i < QUEUE_DEPTH-1) ? i+1 : i];
        q_prio[i] <= q_prio[(i < QUEUE_DEPTH-1) ? i+1 : i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/mcrqs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcrqs_back
// Back end: event sequencer, CPU table, preemption scan and result register.
// ----------------------------------------------------------------------------
module mcrqs_back import mcrqs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_CPUS    = DEF_MAX_CPUS,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    sched_mode,
  input  wire logic [15:0]   slice_ticks,
  input  wire logic [4:0]    active_cpus,
  input  wire logic          cmd_valid,
  input  wire cmd_t          cmd,
  output logic               cmd_pop,
  output rq_ctrl_t           rq_ctrl,
  input  wire logic [CW-1:0] rq_count,
  input  wire logic          rq_full,
  input  wire logic [7:0]    rq_head_proc,
  input  wire logic [7:0]    rq_head_prio,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               kind,
  output logic [3:0]         target_cpu,
  output logic [7:0]         chosen_process,
  output logic               go_idle,
  output logic [15:0]        slice_length,
  output logic               overflow
);

  localparam int NW0  = $clog2(MAX_CPUS + 1);
  localparam int NW   = (NW0 > 5) ? NW0 : 5;
  localparam int CPUW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DISP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]          state;
  cmd_t                cur;
  logic                ovf;
  logic [NW-1:0]       scan_idx;
  logic [7:0]          best;
  logic [NW-1:0]       best_cpu;
  logic                any_idle;

  logic [MAX_CPUS-1:0] cpu_busy;
  logic [7:0]          cpu_proc [MAX_CPUS];
  logic [7:0]          cpu_prio [MAX_CPUS];

  logic [NW-1:0]       n;
  logic [NW-1:0]       cmd_cpu;
  logic [NW-1:0]       cur_cpu;
  logic [CPUW-1:0]     rd_idx;
  logic                rd_busy;
  logic [7:0]          rd_proc;
  logic [7:0]          rd_prio;
  logic                start;
  logic                any_next;
  logic [7:0]          best_next;
  logic [NW-1:0]       best_cpu_next;

  assign n       = (NW'(active_cpus) > NW'(MAX_CPUS)) ? NW'(MAX_CPUS) : NW'(active_cpus);
  assign cmd_cpu = NW'(cmd.cpu_index);
  assign cur_cpu = NW'(cur.cpu_index);
  assign rd_idx  = (state == ST_SCAN) ? scan_idx[CPUW-1:0] : cmd_cpu[CPUW-1:0];
  assign rd_busy = cpu_busy[rd_idx];
  assign rd_proc = cpu_proc[rd_idx];
  assign rd_prio = cpu_prio[rd_idx];
  assign start   = (state == ST_IDLE) && cmd_valid && !out_valid;
  assign cmd_pop = start;

  always_comb begin
    any_next      = any_idle;
    best_next     = best;
    best_cpu_next = best_cpu;
    if (!rd_busy) begin
      any_next = 1'b1;
    end else if (rd_prio > best) begin
      best_next     = rd_prio;
      best_cpu_next = scan_idx;
    end
  end

  always_comb begin
    rq_ctrl           = '0;
    rq_ctrl.prio_mode = (sched_mode == MODE_PRIO);
    if (start) begin
      if (cmd.opcode == OP_WAKE) begin
        rq_ctrl.ins      = !rq_full;
        rq_ctrl.ins_proc = cmd.proc_id;
        rq_ctrl.ins_prio = cmd.proc_priority;
      end else if (cmd.opcode == OP_PREEMPT && cmd_cpu < n && rd_busy) begin
        rq_ctrl.ins      = !rq_full;
        rq_ctrl.ins_proc = rd_proc;
        rq_ctrl.ins_prio = rd_prio;
      end
    end
    if (state == ST_DISP) rq_ctrl.pop = (rq_count != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cpu_busy  <= '0;
      out_valid <= 1'b0;
      ovf       <= 1'b0;
      scan_idx  <= '0;
      any_idle  <= 1'b0;
      best      <= '0;
      best_cpu  <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur <= cmd;
            ovf <= 1'b0;
            if (cmd.opcode == OP_WAKE) begin
              if (rq_full) begin
                out_valid      <= 1'b1;
                kind           <= KIND_DISPATCH;
                target_cpu     <= '0;
                chosen_process <= '0;
                go_idle        <= 1'b0;
                slice_length   <= '0;
                overflow       <= 1'b1;
              end else if (sched_mode == MODE_PRIO && n != '0) begin
                state    <= ST_SCAN;
                scan_idx <= '0;
                best     <= '0;
                best_cpu <= '0;
                any_idle <= 1'b0;
              end
            end else if (cmd.opcode <= OP_IDLE && cmd_cpu < n) begin
              cpu_busy[cmd_cpu[CPUW-1:0]] <= 1'b0;
              if (cmd.opcode == OP_PREEMPT) begin
                ovf   <= rd_busy && rq_full;
                state <= ST_DISP;
              end else if (!(cmd.opcode == OP_IDLE && rq_count == '0)) begin
                state <= ST_DISP;
              end
            end
          end
        end
        ST_DISP: begin
          state          <= ST_IDLE;
          out_valid      <= 1'b1;
          kind           <= KIND_DISPATCH;
          target_cpu     <= cur.cpu_index;
          overflow       <= ovf;
          if (rq_count == '0) begin
            chosen_process <= '0;
            go_idle        <= 1'b1;
            slice_length   <= '0;
          end else begin
            cpu_busy[cur_cpu[CPUW-1:0]] <= 1'b1;
            chosen_process <= rq_head_proc;
            go_idle        <= 1'b0;
            slice_length   <= slice_ticks;
          end
        end
        ST_SCAN: begin
          any_idle <= any_next;
          best     <= best_next;
          best_cpu <= best_cpu_next;
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == n - 1'b1) begin
            state <= ST_IDLE;
            if (!any_next && best_next > cur.proc_priority) begin
              out_valid      <= 1'b1;
              kind           <= KIND_PREEMPT;
              target_cpu     <= best_cpu_next[3:0];
              chosen_process <= '0;
              go_idle        <= 1'b0;
              slice_length   <= '0;
              overflow       <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // CPU table payload
  always_ff @(posedge clk) begin
    if (state == ST_DISP && rq_count != '0) begin
      cpu_proc[cur_cpu[CPUW-1:0]] <= rq_head_proc;
      cpu_prio[cur_cpu[CPUW-1:0]] <= rq_head_prio;
    end
  end

endmodule
`default_nettype wire

// ----- sv/multi_cpu_ready_queue_scheduler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_cpu_ready_queue_scheduler_core
// Ready queue scheduler for several CPUs with APB register access.
// ----------------------------------------------------------------------------
// Items enter a four-deep command queue and are executed one at a time by a
// sequencer. In priority mode a wake scans the CPU table one entry a cycle
// for a preemption victim. Preempt, yield, terminate and idle pass through
// decode and dispatch before the result is registered. A new item starts
// only once the previous result has been taken from the output register.
// Configure only while the block is idle.
// ----------------------------------------------------------------------------
module multi_cpu_ready_queue_scheduler_core import mcrqs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_CPUS    = DEF_MAX_CPUS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  cpu_index,
  input  wire logic [7:0]  proc_id,
  input  wire logic [7:0]  proc_priority,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [3:0]       target_cpu,
  output logic [7:0]       chosen_process,
  output logic             go_idle,
  output logic [15:0]      slice_length,
  output logic             overflow
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [1:0]  sched_mode;
  logic [15:0] slice_ticks;
  logic [4:0]  active_cpus;
  cmd_t        in_cmd;
  cmd_t        cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  rq_ctrl_t    rq_ctrl;
  logic [CW-1:0] rq_count;
  logic        rq_full;
  logic [7:0]  rq_head_proc;
  logic [7:0]  rq_head_prio;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode  <= MODE_FIFO;
      slice_ticks <= '0;
      active_cpus <= 5'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SCHED_MODE:  sched_mode  <= pwdata[1:0];
        REG_SLICE_TICKS: slice_ticks <= pwdata[15:0];
        REG_ACTIVE_CPUS: active_cpus <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SCHED_MODE:  prdata = {30'd0, sched_mode};
      REG_SLICE_TICKS: prdata = {16'd0, slice_ticks};
      REG_ACTIVE_CPUS: prdata = {27'd0, active_cpus};
      default:         prdata = '0;
    endcase
  end

  assign in_cmd = '{opcode: opcode, cpu_index: cpu_index, proc_id: proc_id,
                    proc_priority: proc_priority};

  mcrqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  mcrqs_rdyq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rdyq (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (rq_ctrl),
    .count     (rq_count),
    .full      (rq_full),
    .head_proc (rq_head_proc),
    .head_prio (rq_head_prio)
  );

  mcrqs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_CPUS(MAX_CPUS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .sched_mode     (sched_mode),
    .slice_ticks    (slice_ticks),
    .active_cpus    (active_cpus),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .rq_ctrl        (rq_ctrl),
    .rq_count       (rq_count),
    .rq_full        (rq_full),
    .rq_head_proc   (rq_head_proc),
    .rq_head_prio   (rq_head_prio),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .target_cpu     (target_cpu),
    .chosen_process (chosen_process),
    .go_idle        (go_idle),
    .slice_length   (slice_length),
    .overflow       (overflow)
  );

endmodule
`default_nettype wire
